// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock; all but the last are disabled by reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define BHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off while reset is high
`define BHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define BHT_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bht_pkg.sv =====
// ----------------------------------------------------------------------------
// bht_pkg
// types and codes of the bucketized hash table
// ----------------------------------------------------------------------------
`default_nettype none

package bht_pkg;

   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 64;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 13;

   // operation kinds
   localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_RESERVED  = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  result_value;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/bht_chan_if.sv =====
// ----------------------------------------------------------------------------
// bht_chan_if
// valid/ready channel carrying one payload item per handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface bht_chan_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== sv/bht_ram.sv =====
// ----------------------------------------------------------------------------
// bht_ram
// single-port-write, single-port-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module bht_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // read data holds while no read is issued
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/bucketized_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// bucketized_hash_table_unit
// key-value table of buckets with a few slots each; lookup, insert, remove
// ----------------------------------------------------------------------------
//  port     dir  payload                              role
//  req_ch   in   kind, key, value                     one table operation
//  rsp_ch   out  status, result_value, occupancy      one answer per operation
//
//  an item is a read-modify-write: the bucket line is read from the key and value
//  rams in the accept cycle and rewritten in the exec step.
//  after reset the key ram is cleared one bucket a cycle, one pass over all buckets,
//  with req_ch.ready low. a waiting answer holds the item in its write step;
//  a new item is taken while the answer waits once that step is done.
`default_nettype none

module bucketized_hash_table_unit #(
   parameter int BUCKET_COUNT     = 1024,
   parameter int SLOTS_PER_BUCKET = 4
) (
   input wire logic clock,
   input wire logic reset,
   bht_chan_if.sink   req_ch,
   bht_chan_if.source rsp_ch
);

   localparam int SLOTS   = SLOTS_PER_BUCKET;
   localparam int KEY_W   = bht_pkg::KEY_W;
   localparam int VALUE_W = bht_pkg::VALUE_W;
   localparam int OCC_W   = bht_pkg::OCC_W;
   localparam int ADDR_W  = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(BUCKET_COUNT - 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   typedef logic [SLOTS-1:0][KEY_W-1:0]   key_line_type;
   typedef logic [SLOTS-1:0][VALUE_W-1:0] value_line_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   bht_pkg::req_type  op_ff;
   logic [ADDR_W-1:0] row_ff;
   logic [OCC_W-1:0]  used_ff;
   logic              rsp_valid_ff;
   bht_pkg::rsp_type  rsp_ff;

   logic              accept;
   logic              exec_fire;
   logic [ADDR_W-1:0] req_row;

   key_line_type   key_rd;
   value_line_type val_rd;
   key_line_type   key_wr;
   value_line_type val_wr;

   logic              key_wr_en;
   logic [ADDR_W-1:0] key_wr_addr;
   logic              val_wr_en;

   logic              hit_any;
   logic [SLOT_W-1:0] hit_idx;
   logic              empty_any;
   logic [SLOT_W-1:0] empty_idx;

   logic [bht_pkg::STATUS_W-1:0] status_in;
   logic [VALUE_W-1:0]           result_in;
   logic [OCC_W-1:0]             used_in;
   logic                         ins_ok;
   logic                         rem_ok;

   assign accept    = req_ch.valid && req_ch.ready;
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   assign req_ch.ready   = (state_ff == S_IDLE);
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   // bucket is the low key bits
   always_comb begin
      if (BUCKET_COUNT > 1) begin
         req_row = req_ch.payload.key[ADDR_W-1:0];
      end else begin
         req_row = '0;
      end
   end

   // lowest matching slot and lowest empty slot of the bucket line
   always_comb begin
      hit_any   = 1'b0;
      hit_idx   = '0;
      empty_any = 1'b0;
      empty_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (key_rd[i] == op_ff.key) begin
            hit_any = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (key_rd[i] == '0) begin
            empty_any = 1'b1;
            empty_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      status_in = bht_pkg::STATUS_OK;
      result_in = '0;
      ins_ok    = 1'b0;
      rem_ok    = 1'b0;
      if (op_ff.kind != bht_pkg::KIND_LOOKUP && op_ff.kind != bht_pkg::KIND_INSERT &&
          op_ff.kind != bht_pkg::KIND_REMOVE) begin
         status_in = bht_pkg::STATUS_NOT_FOUND;
      end else if (op_ff.key == '0) begin
         status_in = bht_pkg::STATUS_RESERVED;
      end else begin
         unique case (op_ff.kind)
            bht_pkg::KIND_LOOKUP: begin
               if (hit_any) begin
                  result_in = val_rd[hit_idx];
               end else begin
                  status_in = bht_pkg::STATUS_NOT_FOUND;
               end
            end
            bht_pkg::KIND_INSERT: begin
               if (hit_any) begin
                  status_in = bht_pkg::STATUS_DUPLICATE;
               end else if (empty_any) begin
                  ins_ok = 1'b1;
               end else begin
                  status_in = bht_pkg::STATUS_FULL;
               end
            end
            default: begin
               if (hit_any) begin
                  result_in = val_rd[hit_idx];
                  rem_ok    = 1'b1;
               end else begin
                  status_in = bht_pkg::STATUS_NOT_FOUND;
               end
            end
         endcase
      end
   end

   // count wraps at the occupancy width, same as the reported field
   always_comb begin
      used_in = used_ff;
      if (ins_ok) begin
         used_in = used_ff + OCC_W'(1);
      end else if (rem_ok) begin
         used_in = used_ff - OCC_W'(1);
      end
   end

   // write-back line and port muxing; the clear pass owns the key port
   always_comb begin
      key_wr = key_rd;
      val_wr = val_rd;
      if (ins_ok) begin
         key_wr[empty_idx] = op_ff.key;
         val_wr[empty_idx] = op_ff.value;
      end else if (rem_ok) begin
         key_wr[hit_idx] = '0;
      end
      if (state_ff == S_CLEAR) begin
         key_wr      = '0;
         key_wr_en   = 1'b1;
         key_wr_addr = clr_addr_ff;
      end else begin
         key_wr_en   = exec_fire && (ins_ok || rem_ok);
         key_wr_addr = row_ff;
      end
      val_wr_en = exec_fire && ins_ok;
   end

   bht_ram #(
      .WIDTH (SLOTS * KEY_W),
      .DEPTH (BUCKET_COUNT)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr),
      .rd_en   (accept),
      .rd_addr (req_row),
      .rd_data (key_rd)
   );

   bht_ram #(
      .WIDTH (SLOTS * VALUE_W),
      .DEPTH (BUCKET_COUNT)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (row_ff),
      .wr_data (val_wr),
      .rd_en   (accept),
      .rd_addr (req_row),
      .rd_data (val_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new answer may follow the one leaving in the same cycle
         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
               if (clr_addr_ff == LAST_ROW) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            default: begin
               if (exec_fire) begin
                  used_ff  <= used_in;
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_ch.payload;
         row_ff <= req_row;
      end
      if (exec_fire) begin
         rsp_ff.status       <= status_in;
         rsp_ff.result_value <= result_in;
         rsp_ff.occupancy    <= used_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/bht_checker.sv =====
// ----------------------------------------------------------------------------
// bht_checker
// port-level checks of the bucketized hash table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bht_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire bht_pkg::rsp_type rsp_payload
);

   // a stalled answer keeps its contents
   `BHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "rsp item changed while stalled")

   // a failed operation never returns a value
   `BHT_ASSERT_NOW(a_fail_zero, rsp_valid && rsp_payload.status != bht_pkg::STATUS_OK, rsp_payload.result_value == '0, "nonzero value with failing status")

   // one item in flight: no accept right after an accept
   `BHT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "item accepted during read-modify-write")

   // reset drops the answer and starts the clear pass
   `BHT_ASSERT_NEXT_ALWAYS(a_reset_quiet, reset, !rsp_valid && !req_ready, "ports active right after reset")

endmodule

bind bucketized_hash_table_unit bht_checker u_bht_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload)
);

`default_nettype wire

// ===== tb/bucketized_hash_table_unit_test.sv =====
// ----------------------------------------------------------------------------
// bucketized_hash_table_unit_test
// drives lookup, insert, remove and unused-kind items into the table and checks every
// answer against an in-bench table model, with random gaps on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module bucketized_hash_table_unit_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUCKETS     = 1024;
   localparam int SLOTS       = 4;
   localparam int TABLE_SIZE  = BUCKETS * SLOTS;
   localparam int BUCKET_BITS = $clog2(BUCKETS);
   localparam int SETTLE_CYCLES = 16;
   localparam int POOL_LIMIT  = 64;

   // the one kind code the block does not define
   localparam logic [bht_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic clock;
   logic reset;

   bht_chan_if #(.payload_type(bht_pkg::req_type)) req_ch ();
   bht_chan_if #(.payload_type(bht_pkg::rsp_type)) rsp_ch ();

   bucketized_hash_table_unit #(
      .BUCKET_COUNT     (BUCKETS),
      .SLOTS_PER_BUCKET (SLOTS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // table model
   logic [bht_pkg::KEY_W-1:0]   stored_keys [TABLE_SIZE];
   logic [bht_pkg::VALUE_W-1:0] stored_values [TABLE_SIZE];
   int unsigned                 live_slots;

   bht_pkg::rsp_type            pending_answers [$];
   logic [bht_pkg::KEY_W-1:0]   key_pool [$];
   int unsigned                 errors;
   bit                          req_idle_on;
   bit                          rsp_idle_on;
   int unsigned                 stall_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 15) == 0) begin
         return $urandom_range(16, 48);
      end
      return $urandom_range(1, 4);
   endfunction

   function automatic bht_pkg::rsp_type apply_op(bht_pkg::req_type op);
      bht_pkg::rsp_type answer;
      int unsigned      base;
      int               hit;
      int               empty;
      answer.status       = bht_pkg::STATUS_OK;
      answer.result_value = '0;
      if (op.kind == KIND_UNUSED) begin
         answer.status = bht_pkg::STATUS_NOT_FOUND;
      end else if (op.key == '0) begin
         answer.status = bht_pkg::STATUS_RESERVED;
      end else begin
         base  = int'(op.key[BUCKET_BITS-1:0]) * SLOTS;
         hit   = -1;
         empty = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && stored_keys[base + i] == op.key) hit = base + i;
            if (empty < 0 && stored_keys[base + i] == '0) empty = base + i;
         end
         case (op.kind)
            bht_pkg::KIND_LOOKUP: begin
               if (hit < 0) answer.status = bht_pkg::STATUS_NOT_FOUND;
               else answer.result_value = stored_values[hit];
            end
            bht_pkg::KIND_INSERT: begin
               if (hit >= 0) begin
                  answer.status = bht_pkg::STATUS_DUPLICATE;
               end else if (empty < 0) begin
                  answer.status = bht_pkg::STATUS_FULL;
               end else begin
                  stored_keys[empty]   = op.key;
                  stored_values[empty] = op.value;
                  live_slots++;
               end
            end
            default: begin
               if (hit < 0) begin
                  answer.status = bht_pkg::STATUS_NOT_FOUND;
               end else begin
                  answer.result_value = stored_values[hit];
                  stored_keys[hit]    = '0;
                  if (live_slots > 0) live_slots--;
               end
            end
         endcase
      end
      answer.occupancy = live_slots[bht_pkg::OCC_W-1:0];
      return answer;
   endfunction

   // predict on accepted requests, check accepted answers, same edge
   always @(posedge clock) begin
      bht_pkg::rsp_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) pending_answers.push_back(apply_op(req_ch.payload));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
               $error("answer item with nothing pending: status %0d value %h occupancy %0d",
                      rsp_ch.payload.status, rsp_ch.payload.result_value,
                      rsp_ch.payload.occupancy);
               errors++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ch.payload.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_ch.payload.status);
                  errors++;
               end
               if (rsp_ch.payload.result_value !== want.result_value) begin
                  $error("result_value expected %h actual %h", want.result_value,
                         rsp_ch.payload.result_value);
                  errors++;
               end
               if (rsp_ch.payload.occupancy !== want.occupancy) begin
                  $error("occupancy expected %0d actual %0d", want.occupancy,
                         rsp_ch.payload.occupancy);
                  errors++;
               end
            end
         end
      end
   end

   // answer side back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready = 1'b0;
         stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
         rsp_ch.ready = 1'b0;
         stall_left   = pick_gap() - 1;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // valid stays high after acceptance so the next call can go back to back
   task automatic send_op(input logic [bht_pkg::KIND_W-1:0] kind,
                          input logic [bht_pkg::KEY_W-1:0] key,
                          input logic [bht_pkg::VALUE_W-1:0] value);
      int unsigned gap;
      gap = (req_idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_ch.valid         = 1'b1;
      req_ch.payload.kind  = kind;
      req_ch.payload.key   = key;
      req_ch.payload.value = value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_answers();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic test_reserved_key();
      send_op(bht_pkg::KIND_LOOKUP, '0, rand64());
      send_op(bht_pkg::KIND_INSERT, '0, '1);
      send_op(bht_pkg::KIND_REMOVE, '0, '0);
      // the unused kind answers not found whatever the key
      send_op(KIND_UNUSED, '0, rand64());
      send_op(KIND_UNUSED, '1, '1);
      drain_answers();
   endtask

   task automatic test_single_key();
      send_op(bht_pkg::KIND_INSERT, '1, '1);
      send_op(bht_pkg::KIND_LOOKUP, '1, '0);
      send_op(bht_pkg::KIND_INSERT, '1, 64'h0123_4567_89ab_cdef);
      send_op(bht_pkg::KIND_LOOKUP, '1, '0);
      send_op(bht_pkg::KIND_INSERT, 64'd1, '0);
      send_op(bht_pkg::KIND_REMOVE, '1, '0);
      send_op(bht_pkg::KIND_LOOKUP, '1, '0);
      send_op(bht_pkg::KIND_REMOVE, '1, '0);
      send_op(bht_pkg::KIND_LOOKUP, 64'd1, '1);
      drain_answers();
   endtask

   task automatic test_full_bucket();
      logic [bht_pkg::KEY_W-1:0] base_key;
      base_key = 64'd5;
      for (int i = 0; i <= SLOTS; i++) begin
         send_op(bht_pkg::KIND_INSERT, base_key | (64'(i + 1) << BUCKET_BITS), rand64());
      end
      // free a middle slot, then the refused key fits
      send_op(bht_pkg::KIND_REMOVE, base_key | (64'd2 << BUCKET_BITS), '0);
      send_op(bht_pkg::KIND_INSERT, base_key | (64'(SLOTS + 1) << BUCKET_BITS), rand64());
      send_op(bht_pkg::KIND_LOOKUP, base_key | (64'(SLOTS + 1) << BUCKET_BITS), '0);
      send_op(bht_pkg::KIND_LOOKUP, base_key | (64'd2 << BUCKET_BITS), '0);
      send_op(bht_pkg::KIND_INSERT, base_key | (64'd7 << BUCKET_BITS), '0);
      drain_answers();
   endtask

   function automatic logic [bht_pkg::KEY_W-1:0] pick_key();
      int unsigned               r;
      logic [bht_pkg::KEY_W-1:0] k;
      r = $urandom_range(0, 9);
      if (r < 4 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size() - 1)];
      k = rand64();
      // crowd a few buckets so they fill up
      if (r < 8) k[BUCKET_BITS-1:0] = BUCKET_BITS'($urandom_range(0, 7));
      if (k == '0) k = 64'd1;
      return k;
   endfunction

   task automatic test_random_ops(input int unsigned count);
      int unsigned                r;
      logic [bht_pkg::KIND_W-1:0] kind;
      logic [bht_pkg::KEY_W-1:0]  key;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0) begin
            req_idle_on = ($urandom_range(0, 3) != 0);
            rsp_idle_on = ($urandom_range(0, 3) != 0);
         end
         if (n == count / 2) drain_answers();
         r   = $urandom_range(0, 99);
         key = pick_key();
         if (r < 40) kind = bht_pkg::KIND_INSERT;
         else if (r < 70) kind = bht_pkg::KIND_LOOKUP;
         else if (r < 95) kind = bht_pkg::KIND_REMOVE;
         else kind = KIND_UNUSED;
         if ($urandom_range(0, 49) == 0) key = '0;
         if (kind == bht_pkg::KIND_INSERT && key != '0) begin
            key_pool.push_back(key);
            if (key_pool.size() > POOL_LIMIT) void'(key_pool.pop_front());
         end
         send_op(kind, key, rand64());
      end
      drain_answers();
   endtask

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         stored_keys[i]   = '0;
         stored_values[i] = '0;
      end
      live_slots     = 0;
      errors         = 0;
      stall_left     = 0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reserved_key();
      test_single_key();
      test_full_bucket();
      test_random_ops(500);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/bht_pkg.sv
sv/bht_chan_if.sv
sv/bht_ram.sv
sv/bucketized_hash_table_unit.sv
sv/bht_checker.sv
tb/bucketized_hash_table_unit_test.sv
